// ----- rtl/gtg_pkg.sv -----
// Shared types, constants and the arctangent table of the go-to-goal controller.
`default_nettype none

package gtg_pkg;

  // Number of CORDIC rotation cells in the chain (8 to 24).
  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int TAB_IDX_W     = $clog2(TABLE_LEN);

  // Field widths.
  localparam int POS_W    = 32;
  localparam int DIFF_W   = POS_W + 1;
  localparam int YAW_W    = 16;
  localparam int GAIN_W   = 16;
  localparam int LIM_W    = 15;
  localparam int FWD_W    = 15;
  localparam int TURN_W   = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Datapath widths: CORDIC vector, angle, heading error, distance.
  localparam int XY_W   = 36;
  localparam int Z_W    = 36;
  localparam int ERR_W  = 37;
  localparam int UX_W   = 35;
  localparam int DIST_W = 36;
  localparam int FPROD_W = GAIN_W + DIST_W;
  localparam int TPROD_W = ERR_W + GAIN_W + 1;
  localparam int FRND_W  = FPROD_W - 12;
  localparam int TRND_W  = TPROD_W - 26;

  // Angles in Q.30 radians, speeds in Q3.12.
  localparam logic signed [Z_W-1:0]   PI_Q30     = 36'sd3373259426;
  localparam logic signed [ERR_W-1:0] PI_ERR     = 37'sd3373259426;
  localparam logic signed [ERR_W-1:0] TWO_PI_ERR = 37'sd6746518852;
  localparam logic signed [ERR_W-1:0] THRESH_ERR = 37'sd322122547;
  localparam logic [FWD_W-1:0]        MIN_FWD    = 15'd410;
  localparam logic [31:0]             INV_GAIN   = 32'd2608131496;

  // atan(2^-i) in Q.30, truncated.
  localparam logic [29:0] ATAN_Q30 [TABLE_LEN] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76, 30'h01FFD55B,
    30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
    30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF, 30'h00003FFF, 30'h00001FFF,
    30'h00000FFF, 30'h000007FF, 30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
  };

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_POSITION = 8'd0,
    CFG_GAIN_HEADING  = 8'd1,
    CFG_LIMIT_ANGULAR = 8'd2,
    CFG_LIMIT_LINEAR  = 8'd3
  } cfg_reg_e;

  // Values that ride alongside the vector through the chain.
  typedef struct packed {
    logic                    plan;
    logic                    zero;
    logic signed [YAW_W-1:0] yaw;
  } side_t;

  // One CORDIC cell's worth of state.
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    side_t                  side;
  } cordic_t;

  // Configuration register set.
  typedef struct packed {
    logic [GAIN_W-1:0] gain_position;
    logic [GAIN_W-1:0] gain_heading;
    logic [LIM_W-1:0]  limit_angular;
    logic [LIM_W-1:0]  limit_linear;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [FWD_W-1:0]         forward_speed;
    logic signed [TURN_W-1:0] turn_speed;
    logic                     rotate_only;
    logic                     no_plan;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/gtg_if.sv -----
// Handshake interfaces for the pose, command and configuration channels.
`default_nettype none

interface gtg_pose_if;
  logic                                valid;
  logic                                ready;
  logic signed [gtg_pkg::POS_W-1:0]    robot_x;
  logic signed [gtg_pkg::POS_W-1:0]    robot_y;
  logic signed [gtg_pkg::YAW_W-1:0]    robot_yaw;
  logic signed [gtg_pkg::POS_W-1:0]    goal_x;
  logic signed [gtg_pkg::POS_W-1:0]    goal_y;
  logic                                plan_present;

  modport source (output valid, robot_x, robot_y, robot_yaw, goal_x, goal_y, plan_present,
                  input ready);
  modport sink   (input valid, robot_x, robot_y, robot_yaw, goal_x, goal_y, plan_present,
                  output ready);
endinterface

interface gtg_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [gtg_pkg::FWD_W-1:0]           forward_speed;
  logic signed [gtg_pkg::TURN_W-1:0]   turn_speed;
  logic                                rotate_only;
  logic                                no_plan;

  modport source (output valid, forward_speed, turn_speed, rotate_only, no_plan,
                  input ready);
  modport sink   (input valid, forward_speed, turn_speed, rotate_only, no_plan,
                  output ready);
endinterface

interface gtg_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [gtg_pkg::CFG_IDX_W-1:0]       index;
  logic [gtg_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/go_to_goal_p_controller.sv -----
// Top level of the proportional go-to-goal controller.
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+------------------------------------------------
//   pose_i   | in  | valid/ready  | robot_x, robot_y, robot_yaw, goal_x, goal_y, plan
//   cmd_o    | out | valid/ready  | forward_speed, turn_speed, rotate_only, no_plan
//   cfg_i    | in  | valid/ready  | index, data (always ready)
//
// One item is taken every cycle unless the skid entry is full. An item passes
// through the input difference, pre-rotation, the CORDIC cell chain, four back-end
// stages and the output register. A two-entry output buffer (register plus skid)
// keeps taking items while a result waits; the whole pipe stalls only once the
// skid entry is full. Reset clears valid bits and loads the default gains/limits.
`default_nettype none

module go_to_goal_p_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  gtg_pose_if.sink    pose_i,
  gtg_cmd_if.source   cmd_o,
  gtg_cfg_if.sink     cfg_i
);
  import gtg_pkg::*;

  logic en;

  // Configuration registers.
  cfg_t cfg_q;

  // Input difference stage.
  logic                      s0_valid_q;
  logic signed [DIFF_W-1:0]  dx_q;
  logic signed [DIFF_W-1:0]  dy_q;
  side_t                     s0_side_q;

  // Pre-rotation stage feeds the cell chain.
  cordic_t pre_d;
  cordic_t pre_q;
  logic    pre_valid_q;
  logic signed [XY_W-1:0] dx_ext;
  logic signed [XY_W-1:0] dy_ext;

  cordic_t chain_data  [CORDIC_STAGES+1];
  logic    chain_valid [CORDIC_STAGES+1];

  logic post_valid;
  cmd_t post_cmd;

  // Output register and skid entry.
  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  cmd_t out_q, out_d;
  cmd_t skid_q, skid_d;
  logic arrive;
  logic take;

  assign en           = !skid_valid_q;
  assign pose_i.ready = en;
  assign cfg_i.ready  = 1'b1;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_position <= GAIN_W'(256);
      cfg_q.gain_heading  <= GAIN_W'(256);
      cfg_q.limit_angular <= LIM_W'(4096);
      cfg_q.limit_linear  <= LIM_W'(4096);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_GAIN_POSITION: cfg_q.gain_position <= cfg_i.data[GAIN_W-1:0];
        CFG_GAIN_HEADING:  cfg_q.gain_heading  <= cfg_i.data[GAIN_W-1:0];
        CFG_LIMIT_ANGULAR: cfg_q.limit_angular <= cfg_i.data[LIM_W-1:0];
        CFG_LIMIT_LINEAR:  cfg_q.limit_linear  <= cfg_i.data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Offset from robot to goal.
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= DIFF_W'(pose_i.goal_x) - DIFF_W'(pose_i.robot_x);
      dy_q <= DIFF_W'(pose_i.goal_y) - DIFF_W'(pose_i.robot_y);
      s0_side_q.plan <= pose_i.plan_present;
      s0_side_q.zero <= (pose_i.goal_x == pose_i.robot_x) && (pose_i.goal_y == pose_i.robot_y);
      s0_side_q.yaw  <= pose_i.robot_yaw;
    end
  end

  // Fold a vector in the left half plane onto the right half, starting at plus or minus pi.
  always_comb begin
    dx_ext = XY_W'(dx_q);
    dy_ext = XY_W'(dy_q);
    pre_d.side = s0_side_q;
    if (dx_q[DIFF_W-1]) begin
      pre_d.x = -dx_ext;
      pre_d.y = -dy_ext;
      pre_d.z = dy_q[DIFF_W-1] ? -PI_Q30 : PI_Q30;
    end else begin
      pre_d.x = dx_ext;
      pre_d.y = dy_ext;
      pre_d.z = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pre_q <= pre_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      pre_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q  <= pose_i.valid;
      pre_valid_q <= s0_valid_q;
    end
  end

  assign chain_data[0]  = pre_q;
  assign chain_valid[0] = pre_valid_q;

  // Row of CORDIC cells, one micro-rotation each.
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    gtg_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (TAB_IDX_W'(g)),
      .valid_i (chain_valid[g]),
      .data_i  (chain_data[g]),
      .valid_o (chain_valid[g+1]),
      .data_o  (chain_data[g+1])
    );
  end

  gtg_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (chain_valid[CORDIC_STAGES]),
    .data_i  (chain_data[CORDIC_STAGES]),
    .valid_o (post_valid),
    .cmd_o   (post_cmd)
  );

  // Output register with a skid entry behind it.
  assign arrive = en && post_valid;
  assign take   = out_valid_q && cmd_o.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (arrive) begin
      if (!out_valid_q || take) begin
        out_d       = post_cmd;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = post_cmd;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign cmd_o.valid         = out_valid_q;
  assign cmd_o.forward_speed = out_q.forward_speed;
  assign cmd_o.turn_speed    = out_q.turn_speed;
  assign cmd_o.rotate_only   = out_q.rotate_only;
  assign cmd_o.no_plan       = out_q.no_plan;

endmodule

`default_nettype wire

// ----- rtl/gtg_cordic_cell.sv -----
// One CORDIC vectoring cell: a single micro-rotation toward the x axis.
`default_nettype none

module gtg_cordic_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [gtg_pkg::TAB_IDX_W-1:0] stage_i,
  input  logic                         valid_i,
  input  gtg_pkg::cordic_t             data_i,
  output logic                         valid_o,
  output gtg_pkg::cordic_t             data_o
);
  import gtg_pkg::*;

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [Z_W-1:0]  angle;
  cordic_t                data_d;
  cordic_t                data_q;
  logic                   valid_q;

  // Rotate clockwise while y is non-negative, counterclockwise otherwise.
  always_comb begin
    xs    = data_i.x >>> stage_i;
    ys    = data_i.y >>> stage_i;
    angle = $signed({{(Z_W-30){1'b0}}, ATAN_Q30[stage_i]});
    data_d      = data_i;
    if (!data_i.y[XY_W-1]) begin
      data_d.x = data_i.x + ys;
      data_d.y = data_i.y - xs;
      data_d.z = data_i.z + angle;
    end else begin
      data_d.x = data_i.x - ys;
      data_d.y = data_i.y + xs;
      data_d.z = data_i.z - angle;
    end
  end

  // Valid bit is control state; the vector is payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ----- rtl/gtg_post.sv -----
// Back end: distance scaling, heading error wrap, gains and speed limits.
`default_nettype none

module gtg_post (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  gtg_pkg::cfg_t    cfg_i,
  input  logic             valid_i,
  input  gtg_pkg::cordic_t data_i,
  output logic             valid_o,
  output gtg_pkg::cmd_t    cmd_o
);
  import gtg_pkg::*;

  // Stage valid bits.
  logic [3:0] valid_q;

  // Stage one: low partial product of the gain correction, raw heading error.
  logic [UX_W-1:0]         ux;
  logic signed [ERR_W-1:0] z_ext;
  logic signed [ERR_W-1:0] yaw_ext;
  logic [63:0]             lo_prod_q;
  logic [UX_W-33:0]        hi_q;
  logic signed [ERR_W-1:0] err_raw_q;
  logic                    plan1_q;

  // Stage two: distance and wrapped error.
  logic [DIST_W-1:0]       dist_q;
  logic signed [ERR_W-1:0] err_q;
  logic                    plan2_q;

  // Stage three: gain products and the rotate-only decision.
  logic [FPROD_W-1:0]        fprod_q;
  logic signed [TPROD_W-1:0] tprod_q;
  logic                      rot_q;
  logic                      plan3_q;

  // Stage four: rounding and clamping.
  logic [FRND_W-1:0]         frnd;
  logic signed [TRND_W-1:0]  trnd;
  logic signed [TRND_W-1:0]  tlim;
  logic [FRND_W-1:0]         fsel;
  logic signed [TRND_W-1:0]  tsel;
  cmd_t                      cmd_d;
  cmd_t                      cmd_q;

  always_comb begin
    ux      = (!data_i.x[XY_W-1] && (data_i.x != '0)) ? data_i.x[UX_W-1:0] : '0;
    z_ext   = data_i.side.zero ? '0 : ERR_W'(data_i.z);
    yaw_ext = $signed({{(ERR_W-YAW_W-17){data_i.side.yaw[YAW_W-1]}}, data_i.side.yaw, 17'd0});
  end

  // Round to nearest, floor the shift, then apply floor and limits.
  always_comb begin
    frnd = FRND_W'((fprod_q + FPROD_W'(2048)) >> 12);
    trnd = TRND_W'((tprod_q + TPROD_W'(33554432)) >>> 26);
    tlim = $signed({{(TRND_W-LIM_W){1'b0}}, cfg_i.limit_angular});

    fsel = (frnd < FRND_W'(MIN_FWD)) ? FRND_W'(MIN_FWD) : frnd;
    if (fsel > FRND_W'(cfg_i.limit_linear)) begin
      fsel = FRND_W'(cfg_i.limit_linear);
    end
    tsel = trnd;
    if (tsel > tlim) begin
      tsel = tlim;
    end
    if (tsel < -tlim) begin
      tsel = -tlim;
    end

    cmd_d.forward_speed = rot_q ? '0 : fsel[FWD_W-1:0];
    cmd_d.turn_speed    = tsel[TURN_W-1:0];
    cmd_d.rotate_only   = rot_q;
    cmd_d.no_plan       = 1'b0;
    if (!plan3_q) begin
      cmd_d = '0;
      cmd_d.no_plan = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_prod_q <= ux[31:0] * INV_GAIN;
      hi_q      <= ux[UX_W-1:32];
      err_raw_q <= z_ext - yaw_ext;
      plan1_q   <= data_i.side.plan;

      dist_q  <= DIST_W'(lo_prod_q[63:32]) + DIST_W'(hi_q) * DIST_W'(INV_GAIN);
      if (err_raw_q > PI_ERR) begin
        err_q <= err_raw_q - TWO_PI_ERR;
      end else if (err_raw_q < -PI_ERR) begin
        err_q <= err_raw_q + TWO_PI_ERR;
      end else begin
        err_q <= err_raw_q;
      end
      plan2_q <= plan1_q;

      fprod_q <= FPROD_W'(cfg_i.gain_position) * FPROD_W'(dist_q);
      tprod_q <= TPROD_W'(err_q) * $signed({{(TPROD_W-GAIN_W){1'b0}}, cfg_i.gain_heading});
      rot_q   <= (err_q > THRESH_ERR) || (err_q < -THRESH_ERR);
      plan3_q <= plan2_q;

      cmd_q <= cmd_d;
    end
  end

  assign valid_o = valid_q[3];
  assign cmd_o   = cmd_q;

endmodule

`default_nettype wire
